### hw/rtl/cdh_pkg.sv
package cdh_pkg;

  // Vector components carry the sample scaled by 2^24, plus growth and sign.
  localparam int XY_W      = 43;
  localparam int FRAC_W    = 24;
  localparam int SAMPLE_W  = 16;
  localparam int ANG_W     = 32;
  localparam int HEAD_W    = 15;
  localparam int DECL_W    = 15;
  localparam int ATAN_LEN  = 24;
  localparam int FULL_TURN = 23040;

  localparam logic signed [DECL_W-1:0] DECL_RESET = 15'sd110;
  localparam logic [ANG_W-1:0]         HALF_TURN  = 32'h8000_0000;

  // atan(2^-i) as a 32-bit binary angle
  localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ANG_W-1:0]       ang;
    logic                   zero;
  } vec_t;

endpackage

### hw/rtl/cdh_if.sv
interface cdh_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cdh_pkg::SAMPLE_W-1:0]    field_y;
  logic signed [cdh_pkg::SAMPLE_W-1:0]    field_x;

  modport source (output valid, output field_y, output field_x, input ready);
  modport sink   (input valid, input field_y, input field_x, output ready);
endinterface

interface cdh_heading_if;
  logic                          valid;
  logic                          ready;
  logic [cdh_pkg::HEAD_W-1:0]    heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

interface cdh_cfg_if;
  logic                                valid;
  logic                                ready;
  logic signed [cdh_pkg::DECL_W-1:0]   declination_offset;

  modport source (output valid, output declination_offset, input ready);
  modport sink   (input valid, input declination_offset, output ready);
endinterface

### hw/rtl/compass_heading_degrees.sv
// Compass heading from one magnetometer (y, x) word: a pipelined CORDIC
// vectoring unit finds atan2(y, x), the declination register is added and the
// sum is wrapped into 0..23039 in units of 1/64 degree (a zero vector gives the
// wrapped declination). One word enters per cycle unless the output stalls.
// Its stages are one conditioning stage, one register per CORDIC iteration,
// then the angle-scaling multiply and the wrap stage. The
// pipeline advances as a whole whenever the output register is empty or taken,
// so holding result.ready low stalls every stage. Write the declination only
// while the pipeline is empty; it resets to 110 (1 deg 43 min).
module compass_heading_degrees #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk,
  input  logic          rst,
  cdh_sample_if.sink    sample,
  cdh_heading_if.source result,
  cdh_cfg_if.sink       cfg
);

  localparam int NSTG = (CORDIC_STAGES > cdh_pkg::ATAN_LEN) ? cdh_pkg::ATAN_LEN
                                                            : CORDIC_STAGES;

  logic                              en;
  logic signed [cdh_pkg::DECL_W-1:0] decl;
  logic                              stg_valid [NSTG+1];
  cdh_pkg::vec_t                     stg_vec   [NSTG+1];

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= cdh_pkg::DECL_RESET;
    end else if (cfg.valid) begin
      decl <= cfg.declination_offset;
    end
  end

  cdh_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .field_y   (sample.field_y),
    .field_x   (sample.field_x),
    .out_valid (stg_valid[0]),
    .out_vec   (stg_vec[0])
  );

  for (genvar g = 0; g < NSTG; g++) begin : g_cordic
    cdh_cordic_stage #(
      .SHIFT (g)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[g]),
      .in_vec    (stg_vec[g]),
      .out_valid (stg_valid[g+1]),
      .out_vec   (stg_vec[g+1])
    );
  end

  cdh_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stg_valid[NSTG]),
    .in_vec    (stg_vec[NSTG]),
    .decl      (decl),
    .out_valid (result.valid),
    .heading   (result.heading)
  );

endmodule

### hw/rtl/cdh_prep.sv
module cdh_prep (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [cdh_pkg::SAMPLE_W-1:0]  field_y,
  input  logic signed [cdh_pkg::SAMPLE_W-1:0]  field_x,
  output logic                                 out_valid,
  output cdh_pkg::vec_t                        out_vec
);

  localparam int EXT_W = cdh_pkg::XY_W - cdh_pkg::FRAC_W - cdh_pkg::SAMPLE_W;

  logic signed [cdh_pkg::XY_W-1:0] xs;
  logic signed [cdh_pkg::XY_W-1:0] ys;
  cdh_pkg::vec_t                   vec_next;

  always_comb begin
    xs = {{EXT_W{field_x[cdh_pkg::SAMPLE_W-1]}}, field_x, {cdh_pkg::FRAC_W{1'b0}}};
    ys = {{EXT_W{field_y[cdh_pkg::SAMPLE_W-1]}}, field_y, {cdh_pkg::FRAC_W{1'b0}}};
    vec_next.zero = (field_x == '0) && (field_y == '0);
    // fold the left half-plane onto the right one, starting at 180 degrees
    if (field_x[cdh_pkg::SAMPLE_W-1]) begin
      vec_next.x   = -xs;
      vec_next.y   = -ys;
      vec_next.ang = cdh_pkg::HALF_TURN;
    end else begin
      vec_next.x   = xs;
      vec_next.y   = ys;
      vec_next.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule

### hw/rtl/cdh_cordic_stage.sv
module cdh_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cdh_pkg::vec_t in_vec,
  output logic          out_valid,
  output cdh_pkg::vec_t out_vec
);

  logic signed [cdh_pkg::XY_W-1:0] xs;
  logic signed [cdh_pkg::XY_W-1:0] ys;
  cdh_pkg::vec_t                   vec_next;

  always_comb begin
    xs = in_vec.x >>> SHIFT;
    ys = in_vec.y >>> SHIFT;
    vec_next.zero = in_vec.zero;
    // drive y toward zero
    if (!in_vec.y[cdh_pkg::XY_W-1]) begin
      vec_next.x   = in_vec.x + ys;
      vec_next.y   = in_vec.y - xs;
      vec_next.ang = in_vec.ang + cdh_pkg::ATAN_TAB[SHIFT];
    end else begin
      vec_next.x   = in_vec.x - ys;
      vec_next.y   = in_vec.y + xs;
      vec_next.ang = in_vec.ang - cdh_pkg::ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule

### hw/rtl/cdh_scale.sv
module cdh_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  cdh_pkg::vec_t                      in_vec,
  input  logic signed [cdh_pkg::DECL_W-1:0]  decl,
  output logic                               out_valid,
  output logic [cdh_pkg::HEAD_W-1:0]         heading
);

  localparam int PROD_W = 48;
  localparam int H_W    = PROD_W - cdh_pkg::ANG_W;
  localparam int SUM_W  = H_W + 1;

  localparam logic signed [SUM_W-1:0] TURN_S = SUM_W'(cdh_pkg::FULL_TURN);

  logic [cdh_pkg::ANG_W-1:0]  ang_eff;
  logic [PROD_W-1:0]          prod;
  logic                       mid_valid;
  logic [H_W-1:0]             h;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    wrapped;

  // binary angle to 1/64 degree, rounding halves up
  always_comb begin
    ang_eff = in_vec.zero ? '0 : in_vec.ang;
    prod    = {{(PROD_W - cdh_pkg::ANG_W){1'b0}}, ang_eff} * PROD_W'(cdh_pkg::FULL_TURN)
              + PROD_W'(cdh_pkg::HALF_TURN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h <= prod[PROD_W-1:cdh_pkg::ANG_W];
    end
  end

  // h spans 0..23040 and the offset stays within half a 15-bit range,
  // so one correction either way lands in 0..23039
  always_comb begin
    sum = $signed({1'b0, h}) + $signed({{(SUM_W - cdh_pkg::DECL_W){decl[cdh_pkg::DECL_W-1]}},
                                        decl});
    if (sum[SUM_W-1]) begin
      wrapped = sum + TURN_S;
    end else if (sum >= TURN_S) begin
      wrapped = sum - TURN_S;
    end else begin
      wrapped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= wrapped[cdh_pkg::HEAD_W-1:0];
    end
  end

endmodule
